// ===== rtl/pcm_adaptor_line_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// pcm adaptor line encoder assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef PCM_ADAPTOR_LINE_ENCODER_TOP_ASSERT_SVH
`define PCM_ADAPTOR_LINE_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PCMLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define PCMLE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PCMLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCMLE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/pcmle_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmle_pkg
// shared types and constants of the pcm adaptor line encoder
// ----------------------------------------------------------------------------
package pcmle_pkg;

  // default geometry of the interleave store
  localparam int unsigned DEF_INTERLEAVE_SPACING = 16;
  localparam int unsigned DEF_STORE_DEPTH        = 128;

  // field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WORD_W     = 14;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned LANES      = 6;
  localparam int unsigned LINE_WORDS = 8;
  localparam int unsigned GROUP_W    = SAMPLE_W * LANES;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // arithmetic constants
  localparam logic [WORD_W-1:0] GF_POLY     = 14'h0101;
  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
  localparam logic [WORD_W-1:0] CTRL_WORD_A = 14'h3333;
  localparam logic [WORD_W-1:0] CTRL_WORD_B = 14'h0CCC;

  // sequencer positions
  localparam logic [2:0] TAP_PARITY = 3'd6;
  localparam logic [2:0] TAP_QWORD  = 3'd7;
  localparam logic [2:0] LAST_LANE  = 3'd5;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [3:0] BIT_TOP    = 4'd13;

  // register indexes (address bit 2)
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_EMPH = 1'b1;

  typedef logic [LANES-1:0][SAMPLE_W-1:0]    group_t;
  typedef logic [LINE_WORDS-1:0][WORD_W-1:0] line_t;

  typedef struct packed {
    logic sixteen_bit_mode;
    logic emphasis_on;
  } cfg_t;

  typedef enum logic [2:0] {
    ALU_XOR = 3'b001,
    ALU_GF  = 3'b010,
    ALU_CRC = 3'b100
  } alu_op_e;

  typedef struct packed {
    alu_op_e              op;
    logic [CRC_W-1:0]     acc;
    logic [SAMPLE_W-1:0]  opnd;
    logic                 din;
  } alu_req_t;

endpackage

// ===== rtl/pcmle_if.sv =====
// ----------------------------------------------------------------------------
// pcmle channel interfaces
// request and line channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pcmle_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic               show_line;
  logic signed [15:0] sample_a;
  logic signed [15:0] sample_b;
  logic signed [15:0] sample_c;
  logic signed [15:0] sample_d;
  logic signed [15:0] sample_e;
  logic signed [15:0] sample_f;

  modport source (
    output valid, command, show_line,
    output sample_a, sample_b, sample_c, sample_d, sample_e, sample_f,
    input  ready
  );
  modport sink (
    input  valid, command, show_line,
    input  sample_a, sample_b, sample_c, sample_d, sample_e, sample_f,
    output ready
  );
endinterface

interface pcmle_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] line_word0;
  logic [13:0] line_word1;
  logic [13:0] line_word2;
  logic [13:0] line_word3;
  logic [13:0] line_word4;
  logic [13:0] line_word5;
  logic [13:0] line_word6;
  logic [13:0] line_word7;
  logic [15:0] line_crc;

  modport source (
    output valid, line_word0, line_word1, line_word2, line_word3,
    output line_word4, line_word5, line_word6, line_word7, line_crc,
    input  ready
  );
  modport sink (
    input  valid, line_word0, line_word1, line_word2, line_word3,
    input  line_word4, line_word5, line_word6, line_word7, line_crc,
    output ready
  );
endinterface

// ===== rtl/pcm_adaptor_line_encoder_top.sv =====
// ----------------------------------------------------------------------------
// pcm_adaptor_line_encoder_top
// interleaves audio groups and forms one video line of words plus crc
// ----------------------------------------------------------------------------
// channel   dir  handshake      contents
// in_i      in   valid/ready    command, show_line, sample_a..sample_f
// out_o     out  valid/ready    line_word0..line_word7, line_crc
// apb       in   psel/penable   sixteen_bit_mode at 0x0, emphasis_on at 0x4
//
// a shown 14-bit data line takes 1 store write, 8 taps of an address and a
// data step on the store read port, 12 lane steps of the shared unit and crc
// steps over all 112 line bits; 16-bit mode saves 6 lane steps, a control
// line needs only the crc steps, a store-only request only its write. the
// store needs no clearing pass: a fill count masks entries not yet written.
// a new request is taken once the sequencer is idle; a finished line waits
// in the output register; the sequencer holds the next until it is taken.
// ----------------------------------------------------------------------------
`include "pcm_adaptor_line_encoder_top_assert.svh"

module pcm_adaptor_line_encoder_top #(
  parameter int unsigned INTERLEAVE_SPACING = pcmle_pkg::DEF_INTERLEAVE_SPACING,
  parameter int unsigned STORE_DEPTH        = pcmle_pkg::DEF_STORE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pcmle_in_if.sink                         in_i,
  pcmle_out_if.source                      out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcmle_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pcmle_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pcmle_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import pcmle_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned FW = $clog2(STORE_DEPTH + 1);

  // distance back of each tap, reduced modulo the store depth
  localparam logic [AW-1:0] TAP_DIST [LINE_WORDS] = '{
    AW'(0),
    AW'((1 * INTERLEAVE_SPACING) % STORE_DEPTH),
    AW'((2 * INTERLEAVE_SPACING) % STORE_DEPTH),
    AW'((3 * INTERLEAVE_SPACING) % STORE_DEPTH),
    AW'((4 * INTERLEAVE_SPACING) % STORE_DEPTH),
    AW'((5 * INTERLEAVE_SPACING) % STORE_DEPTH),
    AW'((6 * INTERLEAVE_SPACING) % STORE_DEPTH),
    AW'((7 * INTERLEAVE_SPACING) % STORE_DEPTH)
  };

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WRITE = 7'b0000010,
    ST_RADDR = 7'b0000100,
    ST_RDATA = 7'b0001000,
    ST_LANE  = 7'b0010000,
    ST_CRC   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [2:0]         tap_q, tap_d;
  logic [2:0]         lane_q, lane_d;
  logic [2:0]         wsel_q, wsel_d;
  logic [3:0]         bsel_q, bsel_d;
  logic [CRC_W-1:0]   acc_q, acc_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic               show_q, show_d;
  logic               out_valid_q, out_valid_d;
  group_t             wgrp_q, wgrp_d;
  group_t             grp_q, grp_d;
  line_t              words_q, words_d;
  logic [0:6][1:0]    low_q, low_d;
  line_t              out_words_q, out_words_d;
  logic [CRC_W-1:0]   out_crc_q, out_crc_d;

  logic               ram_we;
  logic [GROUP_W-1:0] ram_rdata;
  logic [AW-1:0]      tap_dist;
  logic [AW-1:0]      tap_addr;
  logic [AW:0]        tap_wrap;
  logic               tap_valid;
  group_t             rd_grp;
  logic               crc_start;
  logic               pos_adv;
  logic               in_fire;
  alu_req_t           alu_req;
  logic [CRC_W-1:0]   alu_res;
  cfg_t               cfg;

  // configuration registers
  pcmle_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // interleave store
  pcmle_ram #(
    .WIDTH (GROUP_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (wgrp_q),
    .raddr_i (tap_addr),
    .rdata_o (ram_rdata)
  );

  // shared step unit
  pcmle_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // tap address: circular subtraction from the current write position
  assign tap_dist  = TAP_DIST[tap_q];
  assign tap_wrap  = {1'b0, pos_q} + (AW+1)'(STORE_DEPTH) - {1'b0, tap_dist};
  assign tap_addr  = (pos_q >= tap_dist) ? (pos_q - tap_dist) : tap_wrap[AW-1:0];
  // entries older than the fill count were never written and read as silence
  assign tap_valid = FW'(tap_dist) < fill_q;
  assign rd_grp    = tap_valid ? group_t'(ram_rdata) : '0;

  assign in_fire    = in_i.valid & in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    tap_d       = tap_q;
    lane_d      = lane_q;
    wsel_d      = wsel_q;
    bsel_d      = bsel_q;
    acc_d       = acc_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    show_d      = show_q;
    wgrp_d      = wgrp_q;
    grp_d       = grp_q;
    words_d     = words_q;
    low_d       = low_q;
    out_words_d = out_words_q;
    out_crc_d   = out_crc_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    ram_we      = 1'b0;
    crc_start   = 1'b0;
    pos_adv     = 1'b0;
    alu_req     = '{op: ALU_CRC, acc: acc_q, opnd: '0, din: words_q[wsel_q][bsel_q]};

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.command) begin
            words_d[0] = CTRL_WORD_A;
            words_d[1] = CTRL_WORD_B;
            words_d[2] = CTRL_WORD_A;
            words_d[3] = CTRL_WORD_B;
            words_d[4] = '0;
            words_d[5] = '0;
            words_d[6] = '0;
            words_d[7] = {12'b0, cfg.sixteen_bit_mode, ~cfg.emphasis_on};
            crc_start  = 1'b1;
          end else begin
            wgrp_d  = {in_i.sample_f, in_i.sample_e, in_i.sample_d,
                       in_i.sample_c, in_i.sample_b, in_i.sample_a};
            show_d  = in_i.show_line;
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        if (fill_q != FW'(STORE_DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
        if (show_q) begin
          tap_d   = '0;
          state_d = ST_RADDR;
        end else begin
          pos_adv = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RADDR: begin
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        if (tap_q < TAP_PARITY) begin
          words_d[tap_q] = rd_grp[tap_q][SAMPLE_W-1:2];
          low_d[tap_q]   = rd_grp[tap_q][1:0];
          tap_d          = tap_q + 1'b1;
          state_d        = ST_RADDR;
        end else if (tap_q == TAP_QWORD && cfg.sixteen_bit_mode) begin
          words_d[7] = low_q;
          pos_adv    = 1'b1;
          crc_start  = 1'b1;
        end else begin
          grp_d   = rd_grp;
          lane_d  = '0;
          acc_d   = '0;
          state_d = ST_LANE;
        end
      end
      ST_LANE: begin
        alu_req = '{op: (tap_q == TAP_PARITY) ? ALU_XOR : ALU_GF, acc: acc_q,
                    opnd: grp_q[lane_q], din: 1'b0};
        acc_d   = alu_res;
        if (lane_q == LAST_LANE) begin
          if (tap_q == TAP_PARITY) begin
            words_d[6] = alu_res[SAMPLE_W-1:2];
            low_d[6]   = alu_res[1:0];
            tap_d      = TAP_QWORD;
            state_d    = ST_RADDR;
          end else begin
            words_d[7] = alu_res[WORD_W-1:0];
            pos_adv    = 1'b1;
            crc_start  = 1'b1;
          end
        end else begin
          lane_d = lane_q + 1'b1;
        end
      end
      ST_CRC: begin
        acc_d = alu_res;
        if (bsel_q == '0) begin
          bsel_d = BIT_TOP;
          wsel_d = wsel_q + 1'b1;
          if (wsel_q == LAST_WORD) begin
            state_d = ST_DONE;
          end
        end else begin
          bsel_d = bsel_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_words_d = words_q;
          out_crc_d   = acc_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // line check starts from all ones at word 0, bit 13
    if (crc_start) begin
      acc_d   = CRC_INIT;
      wsel_d  = '0;
      bsel_d  = BIT_TOP;
      state_d = ST_CRC;
    end

    // advance the circular write position
    if (pos_adv) begin
      pos_d = (pos_q == AW'(STORE_DEPTH - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      lane_q      <= '0;
      wsel_q      <= '0;
      bsel_q      <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      show_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      lane_q      <= lane_d;
      wsel_q      <= wsel_d;
      bsel_q      <= bsel_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      show_q      <= show_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    wgrp_q      <= wgrp_d;
    grp_q       <= grp_d;
    words_q     <= words_d;
    low_q       <= low_d;
    out_words_q <= out_words_d;
    out_crc_q   <= out_crc_d;
  end

  // line output
  assign out_o.valid      = out_valid_q;
  assign out_o.line_word0 = out_words_q[0];
  assign out_o.line_word1 = out_words_q[1];
  assign out_o.line_word2 = out_words_q[2];
  assign out_o.line_word3 = out_words_q[3];
  assign out_o.line_word4 = out_words_q[4];
  assign out_o.line_word5 = out_words_q[5];
  assign out_o.line_word6 = out_words_q[6];
  assign out_o.line_word7 = out_words_q[7];
  assign out_o.line_crc   = out_crc_q;

  // checks
  `PCMLE_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FW'(STORE_DEPTH), "fill count past depth")
  `PCMLE_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "line shown outside done step")
  `PCMLE_ASSERT(a_group_store, clk_i, rst_ni, (in_fire && !in_i.command) |=> (state_q == ST_WRITE), "audio request not stored")
  `PCMLE_ASSERT_NEVER(a_bit_range, clk_i, rst_ni, bsel_q > BIT_TOP || lane_q > LAST_LANE, "bit or lane counter out of range")

endmodule

// ===== rtl/pcmle_ram.sv =====
// ----------------------------------------------------------------------------
// pcmle_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module pcmle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/pcmle_alu.sv =====
// ----------------------------------------------------------------------------
// pcmle_alu
// shared step unit: parity xor, gf(2^14) horner step, crc bit step
// ----------------------------------------------------------------------------
module pcmle_alu (
  input  pcmle_pkg::alu_req_t        req_i,
  output logic [pcmle_pkg::CRC_W-1:0] res_o
);
  import pcmle_pkg::*;

  logic [WORD_W-1:0] gf_in;
  logic [WORD_W-1:0] gf_shl;
  logic              crc_fb;

  // gf step: multiply (acc ^ word) by t modulo x^14+x^8+1
  assign gf_in  = req_i.acc[WORD_W-1:0] ^ req_i.opnd[SAMPLE_W-1:2];
  assign gf_shl = {gf_in[WORD_W-2:0], 1'b0} ^ (gf_in[WORD_W-1] ? GF_POLY : '0);

  // crc step: one message bit, msb first
  assign crc_fb = req_i.acc[CRC_W-1] ^ req_i.din;

  always_comb begin
    case (req_i.op)
      ALU_XOR: res_o = req_i.acc ^ req_i.opnd;
      ALU_GF:  res_o = {2'b00, gf_shl};
      ALU_CRC: res_o = {req_i.acc[CRC_W-2:0], 1'b0} ^ (crc_fb ? CRC_POLY : '0);
      default: res_o = req_i.acc;
    endcase
  end

endmodule

// ===== rtl/pcmle_apb_regs.sv =====
// ----------------------------------------------------------------------------
// pcmle_apb_regs
// apb configuration registers: layout mode and emphasis flag
// ----------------------------------------------------------------------------
module pcmle_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [pcmle_pkg::APB_ADDR_W-1:0]    paddr_i,
  input  logic [pcmle_pkg::APB_DATA_W-1:0]    pwdata_i,
  output logic [pcmle_pkg::APB_DATA_W-1:0]    prdata_o,
  output logic                                pready_o,
  output pcmle_pkg::cfg_t                     cfg_o
);
  import pcmle_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign reg_sel  = paddr_i[2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_MODE: cfg_d.sixteen_bit_mode = pwdata_i[0];
        REG_EMPH: cfg_d.emphasis_on      = pwdata_i[0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_MODE: prdata_o = {{(APB_DATA_W-1){1'b0}}, cfg_q.sixteen_bit_mode};
      REG_EMPH: prdata_o = {{(APB_DATA_W-1){1'b0}}, cfg_q.emphasis_on};
      default:  prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
